// ===== sv/dual_role_mouse_modifier_resolver_top_assert.svh =====
// Assertion macros for the dual-role mouse/modifier resolver checker.
// Self-contained: expects clk and rst_n to be visible where a macro is used.
`ifndef DUAL_ROLE_MOUSE_MODIFIER_RESOLVER_TOP_ASSERT_SVH
`define DUAL_ROLE_MOUSE_MODIFIER_RESOLVER_TOP_ASSERT_SVH

// Property checked outside reset.
`define DMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define DMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dmr_pkg.sv =====
// Shared types, codes and the HID modifier table of the resolver.
// No dependencies; every other file but the assertion macro header uses it through scoped names.
package dmr_pkg;

  localparam int KEY_COUNT = 4;

  typedef logic [KEY_COUNT-1:0] key_mask_t;
  typedef logic [1:0]           key_idx_t;

  // Event codes
  localparam logic       FUNC_KEY          = 1'b0;
  localparam logic       FUNC_POINTER      = 1'b1;
  localparam logic [2:0] KIND_PLAIN_BUTTON = 3'd4;

  typedef struct packed {
    logic       func;
    logic       key_pressed;
    logic [2:0] key_kind;
    logic       moved;
    logic       scrolled;
    logic [7:0] active_mods;
  } in_word_t;

  typedef struct packed {
    key_mask_t mods_down;
    key_mask_t mods_up;
    key_mask_t buttons_down;
    key_mask_t buttons_up;
    key_mask_t buttons_tap;
    logic      leave_mouse_mode;
    logic      pass_on;
  } out_word_t;

  // Input register to core
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } in_stage_t;

  // HID modifier bit of a key index: shift, alt, gui, ctrl
  function automatic logic [7:0] hid_bit(key_idx_t idx);
    logic [7:0] bits;
    unique case (idx)
      2'd0:    bits = 8'h02;
      2'd1:    bits = 8'h04;
      2'd2:    bits = 8'h08;
      default: bits = 8'h01;
    endcase
    return bits;
  endfunction

endpackage

// ===== sv/dmr_ifs.sv =====
// Valid/ready channel interfaces for the resolver's input and result words.
// Depends on dmr_pkg for the payload types.
interface dmr_in_if;
  logic             valid;
  logic             ready;
  dmr_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmr_out_if;
  logic               valid;
  logic               ready;
  dmr_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/dmr_in_reg.sv =====
// Input register stage: captures one word per cycle from the input channel while empty or drained by the core.
// Depends on dmr_pkg and dmr_ifs.
module dmr_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  dmr_in_if.sink              in_ch,
  input  logic                advance,
  output dmr_pkg::in_stage_t  stage
);

  logic              valid_r, valid_nxt;
  dmr_pkg::in_word_t word_r;

  // Free when empty or when the core drains the held word this cycle
  assign in_ch.ready = !valid_r || advance;
  assign valid_nxt   = in_ch.ready ? in_ch.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r <= in_ch.data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.word  = word_r;

endmodule

// ===== sv/dmr_core.sv =====
// Per-key role state, resolve logic and the result register.
// Depends on dmr_pkg and dmr_ifs.
module dmr_core (
  input  logic               clk,
  input  logic               rst_n,
  input  dmr_pkg::in_stage_t stage,
  output logic               advance,
  dmr_out_if.source          out_ch
);

  dmr_pkg::key_mask_t held_r, held_nxt;
  dmr_pkg::key_mask_t asm_r, asm_nxt;   // resolved as modifier
  dmr_pkg::key_mask_t asb_r, asb_nxt;   // resolved as held button
  dmr_pkg::key_mask_t map_r, map_nxt;   // foreign mods active at press
  dmr_pkg::key_mask_t eor_r, eor_nxt;   // leave mouse mode on release
  logic               out_valid_r, out_valid_nxt;
  dmr_pkg::out_word_t out_word_r;
  dmr_pkg::out_word_t res;
  logic               fire;

  assign advance       = !out_valid_r || out_ch.ready;
  assign fire          = stage.valid && advance;
  assign out_valid_nxt = advance ? stage.valid : out_valid_r;

  // Resolve one word against the current role state
  always_comb begin
    dmr_pkg::key_mask_t und;
    dmr_pkg::key_mask_t kmask;
    dmr_pkg::key_mask_t hit;
    dmr_pkg::key_idx_t  kidx;
    logic               special;
    logic               other;
    logic               map_new;
    logic [7:0]         ours;

    held_nxt = held_r;
    asm_nxt  = asm_r;
    asb_nxt  = asb_r;
    map_nxt  = map_r;
    eor_nxt  = eor_r;
    res      = '0;

    und     = held_r & ~asm_r & ~asb_r & ~map_r;
    kidx    = stage.word.key_kind[1:0];
    special = !stage.word.key_kind[2];
    other   = !special && (stage.word.key_kind != dmr_pkg::KIND_PLAIN_BUTTON);
    kmask   = '0;
    if (special) begin
      kmask[kidx] = 1'b1;
    end

    // Modifier bits owned by other held keys that took no foreign mods
    ours = '0;
    for (int i = 0; i < dmr_pkg::KEY_COUNT; i++) begin
      if ((dmr_pkg::key_idx_t'(i) != kidx) && held_r[i] && !map_r[i]) begin
        ours = ours | dmr_pkg::hid_bit(dmr_pkg::key_idx_t'(i));
      end
    end
    map_new = |(stage.word.active_mods & ~ours);
    hit     = und & ~kmask;

    if (stage.word.func == dmr_pkg::FUNC_POINTER) begin
      // Motion wins over scroll
      if (stage.word.moved) begin
        asb_nxt          = asb_r | und;
        res.buttons_down = und;
      end else if (stage.word.scrolled) begin
        asm_nxt       = asm_r | und;
        res.mods_down = und;
      end
    end else begin
      // Any press resolves undecided held keys as modifiers
      if (stage.word.key_pressed) begin
        asm_nxt       = asm_r | hit;
        res.mods_down = hit;
        if (other) begin
          eor_nxt = eor_r | hit;
        end
      end

      if (special) begin
        if (stage.word.key_pressed) begin
          held_nxt[kidx]         = 1'b1;
          asm_nxt[kidx]          = 1'b0;
          asb_nxt[kidx]          = 1'b0;
          map_nxt[kidx]          = map_new;
          eor_nxt[kidx]          = 1'b0;
          res.buttons_down[kidx] = map_new;
        end else begin
          priority if (map_r[kidx] || asb_r[kidx]) begin
            res.buttons_up[kidx] = 1'b1;
          end else if (asm_r[kidx]) begin
            res.mods_up[kidx] = 1'b1;
          end else begin
            res.buttons_tap[kidx] = 1'b1;
          end
          res.leave_mouse_mode = eor_r[kidx];
          held_nxt[kidx]       = 1'b0;
          asm_nxt[kidx]        = 1'b0;
          asb_nxt[kidx]        = 1'b0;
          eor_nxt[kidx]        = 1'b0;
        end
      end else begin
        res.pass_on = 1'b1;
      end
    end
  end

  // Control state and role flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      asm_r       <= '0;
      asb_r       <= '0;
      map_r       <= '0;
      eor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        held_r <= held_nxt;
        asm_r  <= asm_nxt;
        asb_r  <= asb_nxt;
        map_r  <= map_nxt;
        eor_r  <= eor_nxt;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

endmodule

// ===== sv/dual_role_mouse_modifier_resolver_top.sv =====
// Top level of the dual-role mouse/modifier resolver.
// Depends on dmr_pkg, dmr_ifs, dmr_in_reg and dmr_core.
//
// Usage:
//  in_ch carries one event word per handshake (valid/ready): a key press or
//  release of a dual-role key, a plain mouse button or any other key, or a
//  pointer report. out_ch returns exactly one result word per event with the
//  modifier and button masks, the leave-mouse-mode request and pass_on.
//  Path: an accepted word is captured by the input register, then the resolve
//  logic writes its result into the result register, which drives out_ch.
//  Throughput: one word per cycle while the receiver does not stall; the
//  four per-key role flag sets are updated as each word resolves.
//  Reset (rst_n low, synchronous): all role flags clear, both stages empty.
//  When the receiver stalls, the result word holds on out_ch; the input
//  register takes one more word only if it is empty, after which in_ch.ready
//  drops until the result is taken.
module dual_role_mouse_modifier_resolver_top (
  input logic       clk,
  input logic       rst_n,
  dmr_in_if.sink    in_ch,
  dmr_out_if.source out_ch
);

  dmr_pkg::in_stage_t stage;
  logic               advance;

  dmr_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  dmr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

// ===== sv/dmr_checker.sv =====
// Port-level checker for the resolver, bound into the top level.
// Depends on dmr_pkg and the assertion macro header.
`include "dual_role_mouse_modifier_resolver_top_assert.svh"

module dmr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input dmr_pkg::out_word_t out_data
);

  // A stalled result word stays put
  `DMR_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_data),
    "result word changed while stalled")

  // A release concerns one key: at most one release action per word
  `DMR_ASSERT(a_one_release,
    out_valid |-> $countones({out_data.mods_up, out_data.buttons_up,
                              out_data.buttons_tap}) <= 1,
    "more than one release action")

  // A passed-on event carries no release action
  `DMR_ASSERT(a_pass_clean,
    out_valid && out_data.pass_on |-> (out_data.mods_up == 4'd0) &&
      (out_data.buttons_up == 4'd0) && (out_data.buttons_tap == 4'd0) &&
      !out_data.leave_mouse_mode,
    "pass_on word carries release")

  // Reset empties the result stage
  `DMR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind dual_role_mouse_modifier_resolver_top dmr_checker u_dmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
